@@ sv/sbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// sbcs_pkg
// shared constants for the slew-aware cubic buss shaper
// ----------------------------------------------------------------------------
`default_nettype none

package sbcs_pkg;

  // default sample width and fixed gain/rate formats
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int GAIN_W          = 26;   // smoothed gain, unsigned Q2.24
  localparam int TARGET_W        = 24;   // gain target, unsigned Q2.22
  localparam int RATE_W          = 16;   // rate scale, unsigned Q4.12
  localparam int CHASE_W         = 28;   // chase speed, unsigned Q12.16
  localparam int NUM_W           = 55;   // gain update dividend
  localparam int DEN_W           = 28;   // gain update divisor
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_TARGET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 8'd1;

  localparam logic [TARGET_W-1:0] GAIN_TARGET_RST = 24'd4194304;
  localparam logic [RATE_W-1:0]   RATE_SCALE_RST  = 16'd4096;

  // chase speed constants
  localparam logic [31:0]        DECAY_Q32   = 32'd4294537799;
  localparam logic [CHASE_W-1:0] DECAY_SUB   = 28'd655;
  localparam logic [CHASE_W-1:0] CHASE_FLOOR = 28'd22937600;   // 350 << 16
  localparam logic [CHASE_W-1:0] CHASE_CAP   = 28'd163840000;  // 2500 << 16

endpackage

`default_nettype wire

@@ sv/sbcs_div.sv @@
// ----------------------------------------------------------------------------
// sbcs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sbcs_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [sbcs_pkg::NUM_W-1:0]   num,
  input  wire logic [sbcs_pkg::DEN_W-1:0]   den,
  output logic                              done,
  output logic [sbcs_pkg::NUM_W-1:0]        quo
);

  localparam int NW = sbcs_pkg::NUM_W;
  localparam int DW = sbcs_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ sv/sbcs_lane.sv @@
// ----------------------------------------------------------------------------
// sbcs_lane
// per-channel gain, cubic boost and slew reduction, five register stages
// ----------------------------------------------------------------------------
`default_nettype none

module sbcs_lane #(
  parameter int SAMPLE_BITS = sbcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic signed [SAMPLE_BITS-1:0]     sample,
  input  wire logic [sbcs_pkg::GAIN_W-1:0]       gain,
  input  wire logic [sbcs_pkg::RATE_W-1:0]       rate,
  input  wire logic signed [SAMPLE_BITS+1:0]     last,
  output logic signed [SAMPLE_BITS-1:0]          shaped,
  output logic signed [SAMPLE_BITS+1:0]          scaled
);

  localparam int SB  = SAMPLE_BITS;
  localparam int F   = SB - 1;
  localparam int GW  = sbcs_pkg::GAIN_W;
  localparam int RW  = sbcs_pkg::RATE_W;
  localparam int YW  = SB + 2;          // scaled magnitude
  localparam int QW  = SB + 4;          // square
  localparam int CBW = SB + 6;          // cube
  localparam int DMW = SB + 3;          // slew distance
  localparam int SLW = DMW + RW - 12;   // slew before clamp
  localparam int P1W = SB + GW;
  localparam int P2W = 2 * YW;
  localparam int P3W = QW + YW;
  localparam int P4W = DMW + RW;
  localparam int P5W = CBW + SB;
  localparam int OW  = SB + 7;

  localparam logic [P1W-1:0] RND1 = {{(P1W-1){1'b0}}, 1'b1} << 23;
  localparam logic [P2W-1:0] RND2 = {{(P2W-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [P3W-1:0] RND3 = {{(P3W-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [P4W-1:0] RND4 = {{(P4W-1){1'b0}}, 1'b1} << 11;
  localparam logic [P5W-1:0] RND5 = {{(P5W-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [SLW-1:0] ONE_SL = {{(SLW-1){1'b0}}, 1'b1} << F;
  localparam logic [SB-1:0]  ONE_S  = {{(SB-1){1'b0}}, 1'b1} << F;
  localparam logic signed [OW-1:0] OMAX = (OW'(1) << F) - OW'(1);
  localparam logic signed [OW-1:0] OMIN = -(OW'(1) << F);

  // stage 1: gain
  logic          neg0;
  logic [SB-1:0] mag0;
  logic [P1W-1:0] p1;
  logic [YW-1:0] ymag1;
  logic          neg1;

  assign neg0 = sample[SB-1];
  assign mag0 = neg0 ? SB'(-sample) : SB'(sample);
  assign p1   = P1W'(mag0) * P1W'(gain) + RND1;

  always_ff @(posedge clk) begin
    ymag1 <= YW'(p1 >> 24);
    neg1  <= neg0;
  end

  // stage 2: square and slew distance
  logic signed [YW-1:0]  y1;
  logic signed [DMW-1:0] d1;
  logic [P2W-1:0] p2;
  logic [QW-1:0]  sq2;
  logic [YW-1:0]  ymag2;
  logic [DMW-1:0] dmag2;
  logic signed [YW-1:0] y2;
  logic           neg2;

  assign y1 = neg1 ? -$signed(ymag1) : $signed(ymag1);
  assign d1 = DMW'(y1) - DMW'(last);
  assign p2 = P2W'(ymag1) * P2W'(ymag1) + RND2;

  always_ff @(posedge clk) begin
    sq2   <= QW'(p2 >> F);
    ymag2 <= ymag1;
    dmag2 <= d1[DMW-1] ? DMW'(-d1) : DMW'(d1);
    y2    <= y1;
    neg2  <= neg1;
  end

  // stage 3: cube and slew factor
  logic [P3W-1:0] p3;
  logic [P4W-1:0] p4;
  logic [SLW-1:0] slew;
  logic [CBW-1:0] cube3;
  logic [SB-1:0]  keep3;
  logic signed [YW-1:0] y3;
  logic           neg3;

  assign p3   = P3W'(sq2) * P3W'(ymag2) + RND3;
  assign p4   = P4W'(dmag2) * P4W'(rate) + RND4;
  assign slew = SLW'(p4 >> 12);

  always_ff @(posedge clk) begin
    cube3 <= CBW'(p3 >> F);
    keep3 <= (slew > ONE_SL) ? '0 : ONE_S - SB'(slew);
    y3    <= y2;
    neg3  <= neg2;
  end

  // stage 4: reduced boost
  logic [P5W-1:0] p5;
  logic [CBW-1:0] half4;
  logic signed [YW-1:0] y4;
  logic           neg4;

  assign p5 = P5W'(cube3) * P5W'(keep3) + RND5;

  always_ff @(posedge clk) begin
    half4 <= CBW'(p5 >> F);
    y4    <= y3;
    neg4  <= neg3;
  end

  // stage 5: sum and saturate
  logic signed [OW-1:0] sum5;

  assign sum5 = neg4 ? OW'(y4) - $signed(OW'(half4)) : OW'(y4) + $signed(OW'(half4));

  always_ff @(posedge clk) begin
    if (sum5 > OMAX) begin
      shaped <= SB'(OMAX);
    end else if (sum5 < OMIN) begin
      shaped <= SB'(OMIN);
    end else begin
      shaped <= SB'(sum5);
    end
  end

  assign scaled = y4;

endmodule

`default_nettype wire

@@ sv/stereo_slew_aware_cubic_buss_shaper.sv @@
// ----------------------------------------------------------------------------
// stereo_slew_aware_cubic_buss_shaper
// stereo cubic buss shaper with smoothed trim gain and slew-aware boost
// ----------------------------------------------------------------------------
//
//   channel  handshake             payload
//   -------  --------------------  ---------------------------
//   in       in_valid / in_stall   left_in, right_in
//   out      out_valid / out_stall left_out, right_out
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a request runs from accept through the chase speed update and gain product,
// the serial gain divider, and the lanes and merge; the block returns to idle
// before it takes the next request
// one request at a time; in_stall is high from accept until the result is
// loaded into the output register, which may still wait on out_stall
// synchronous reset; cfg_ready is always high
//
`default_nettype none

module stereo_slew_aware_cubic_buss_shaper #(
  parameter int SAMPLE_BITS = sbcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input samples
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]         left_in,
  input  wire logic signed [SAMPLE_BITS-1:0]         right_in,
  // shaped samples
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]              left_out,
  output logic signed [SAMPLE_BITS-1:0]              right_out,
  // register writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [sbcs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [sbcs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SB  = SAMPLE_BITS;
  localparam int CW  = sbcs_pkg::CHASE_W;
  localparam int GW  = sbcs_pkg::GAIN_W;
  localparam int TW  = sbcs_pkg::TARGET_W;
  localparam int RW  = sbcs_pkg::RATE_W;
  localparam int NW  = sbcs_pkg::NUM_W;
  localparam int DW  = sbcs_pkg::DEN_W;
  localparam int LANE_LAT = 5;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMUL  = 3'd1;  // chase speed times decay
  localparam logic [2:0] S_CUPD  = 3'd2;  // round, subtract, floor
  localparam logic [2:0] S_GMUL  = 3'd3;  // gain numerator, start divider
  localparam logic [2:0] S_DIV   = 3'd4;  // wait for quotient
  localparam logic [2:0] S_SHAPE = 3'd5;  // wait for lanes, merge result

  logic [2:0] state;

  // configuration registers
  logic [TW-1:0] gain_target;
  logic [RW-1:0] rate_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_target <= sbcs_pkg::GAIN_TARGET_RST;
      rate_scale  <= sbcs_pkg::RATE_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbcs_pkg::REG_GAIN_TARGET: gain_target <= cfg_data[TW-1:0];
        sbcs_pkg::REG_RATE_SCALE:  rate_scale  <= cfg_data[RW-1:0];
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  // smoothing state
  logic [CW-1:0]        chase_rate;
  logic [GW-1:0]        smoothed_gain;
  logic                 chase_loaded;
  logic [TW-1:0]        previous_target;
  logic signed [SB+1:0] last_left;
  logic signed [SB+1:0] last_right;

  // held request
  logic signed [SB-1:0] left_hold;
  logic signed [SB-1:0] right_hold;
  logic [59:0]          decay_prod;
  logic [2:0]           lane_cnt;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // chase speed on accept: double on target change, then cap
  logic [CW:0] chase_dbl;
  logic [CW:0] chase_sel;
  assign chase_dbl = {chase_rate, 1'b0};
  assign chase_sel = (gain_target != previous_target) ? chase_dbl : {1'b0, chase_rate};

  // decay rounding and floor
  logic [CW-1:0] chase_dec;
  logic [CW-1:0] chase_sub;
  assign chase_dec = CW'((decay_prod + 60'h0_8000_0000) >> 32);
  assign chase_sub = (chase_dec > sbcs_pkg::DECAY_SUB) ? chase_dec - sbcs_pkg::DECAY_SUB : '0;

  // gain update operands: (g*c + target<<18 + den/2) / den
  logic [DW-1:0] den;
  logic [NW-1:0] num;
  assign den = DW'(chase_rate) + DW'(65536);
  assign num = NW'(smoothed_gain) * NW'(chase_rate) + (NW'(gain_target) << 18)
             + NW'(den >> 1);

  logic          div_done;
  logic [NW-1:0] quo;

  sbcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_GMUL),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // two lanes share the smoothed gain and rate, each keeps its own history
  logic signed [SB-1:0] left_shaped;
  logic signed [SB-1:0] right_shaped;
  logic signed [SB+1:0] left_scaled;
  logic signed [SB+1:0] right_scaled;

  sbcs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
    .clk    (clk),
    .sample (left_hold),
    .gain   (smoothed_gain),
    .rate   (rate_scale),
    .last   (last_left),
    .shaped (left_shaped),
    .scaled (left_scaled)
  );

  sbcs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
    .clk    (clk),
    .sample (right_hold),
    .gain   (smoothed_gain),
    .rate   (rate_scale),
    .last   (last_right),
    .shaped (right_shaped),
    .scaled (right_scaled)
  );

  // merge both lanes into the output register once it is free
  logic lanes_ready;
  logic out_free;
  assign lanes_ready = (state == S_SHAPE) && (lane_cnt == 3'(LANE_LAT));
  assign out_free    = !out_valid || !out_stall;

  // output valid: set on merge, cleared when the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lanes_ready && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      chase_rate      <= '0;
      smoothed_gain   <= '0;
      chase_loaded    <= 1'b0;
      previous_target <= '0;
      last_left       <= '0;
      last_right      <= '0;
      lane_cnt        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            previous_target <= gain_target;
            chase_rate <= (chase_sel > (CW+1)'(sbcs_pkg::CHASE_CAP))
                        ? sbcs_pkg::CHASE_CAP : chase_sel[CW-1:0];
            if (!chase_loaded) begin
              // first request loads the gain directly
              smoothed_gain <= {gain_target, 2'b00};
              chase_loaded  <= 1'b1;
            end
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          state <= S_CUPD;
        end
        S_CUPD: begin
          chase_rate <= (chase_sub < sbcs_pkg::CHASE_FLOOR) ? sbcs_pkg::CHASE_FLOOR : chase_sub;
          state      <= S_GMUL;
        end
        S_GMUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            smoothed_gain <= (|quo[NW-1:GW]) ? {GW{1'b1}} : quo[GW-1:0];
            lane_cnt      <= '0;
            state         <= S_SHAPE;
          end
        end
        S_SHAPE: begin
          if (!lanes_ready) begin
            lane_cnt <= lane_cnt + 1'b1;
          end else if (out_free) begin
            last_left  <= left_scaled;
            last_right <= right_scaled;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      left_hold  <= left_in;
      right_hold <= right_in;
    end
    if (state == S_CMUL) begin
      decay_prod <= 60'(chase_rate) * 60'(sbcs_pkg::DECAY_Q32);
    end
    if (lanes_ready && out_free) begin
      left_out  <= left_shaped;
      right_out <= right_shaped;
    end
  end

endmodule

`default_nettype wire

@@ dv/stereo_slew_aware_cubic_buss_shaper_tb.sv @@
// ----------------------------------------------------------------------------
// stereo_slew_aware_cubic_buss_shaper_tb
// self-checking bench for the stereo slew-aware cubic buss shaper
//
// a bit-exact predictor of the smoothed trim gain, the chase speed and the
// slew-reduced cubic boost runs beside the block; each accepted request
// queues the shaped pair it should produce, and every result leaving the
// block is compared field by field with the oldest one. directed corner
// requests, register sweeps, random traffic in several gain and rate
// settings and a long output hold-off that backs the block up are run in turn
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_slew_aware_cubic_buss_shaper_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW         = sbcs_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC       = SW - 1;
  localparam longint ONE_S  = 64'd1 << FRAC;
  localparam longint unsigned GAIN_LIMIT = (64'd1 << sbcs_pkg::GAIN_W) - 1;
  localparam longint CYCLE_LIMIT = 1_000_000;
  // beyond the register list
  localparam logic [sbcs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

  typedef logic signed [SW-1:0] sample_t;
  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  // ---------------------------------------------------------------- dut ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t left_in = '0;
  sample_t right_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t left_out;
  sample_t right_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sbcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sbcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stereo_slew_aware_cubic_buss_shaper #(.SAMPLE_BITS(SW)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_stall(out_stall), .left_out(left_out),
    .right_out(right_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ------------------------------------------------------- predictor state
  longint unsigned trim_target;
  longint unsigned slew_rate;
  longint unsigned chase_speed;
  longint unsigned gain_smooth;
  bit              gain_loaded;
  longint unsigned seen_target;
  longint          prev_left;
  longint          prev_right;

  stereo_pair_t shaped_pairs_q[$];
  int  error_count = 0;
  longint cycle_count = 0;

  // idling controls shared with the receiver
  bit  no_idle = 1'b0;         // burst stretches with no gaps on either side
  int  hold_off_cycles = 0;    // one-shot long output hold-off

  // (a*b + half) >> s on a 128-bit product, rounding the magnitude
  function automatic longint unsigned round_mul_shift(longint unsigned a,
                                                      longint unsigned b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    return p[63:0] >> s | (p[127:64] << (64 - s));
  endfunction

  // scale one channel, add the slew-reduced cube, saturate
  function automatic sample_t shape_channel(sample_t raw, ref longint prev);
    longint x, y, d, h, res;
    longint unsigned mag, ymag, sq, cube, dmag, slew, boost;
    bit neg;
    x    = raw;
    neg  = x < 0;
    mag  = neg ? -x : x;
    ymag = round_mul_shift(mag, gain_smooth, 24);
    y    = neg ? -longint'(ymag) : longint'(ymag);
    sq   = round_mul_shift(ymag, ymag, FRAC);
    cube = round_mul_shift(sq, ymag, FRAC);
    d    = y - prev;
    dmag = d < 0 ? -d : d;
    slew = round_mul_shift(dmag, slew_rate, 12);
    if (slew > ONE_S) slew = ONE_S;
    boost = round_mul_shift(cube, ONE_S - slew, FRAC);
    prev = y;
    h    = longint'(boost);
    res  = neg ? y - h : y + h;
    if (res > ONE_S - 1) res = ONE_S - 1;
    if (res < -ONE_S) res = -ONE_S;
    return sample_t'(res);
  endfunction

  // advance the gain smoother by one sample and shape the pair
  function automatic stereo_pair_t predict_shaped_pair(sample_t l, sample_t r);
    longint unsigned c, num, den, g;
    stereo_pair_t p;
    c = chase_speed;
    // a target change doubles the chase speed
    if (trim_target != seen_target) begin
      c = c * 2;
      seen_target = trim_target;
    end
    if (c > sbcs_pkg::CHASE_CAP) c = sbcs_pkg::CHASE_CAP;
    // very first sample loads the smoothed gain straight from the target
    if (!gain_loaded) begin
      gain_smooth = trim_target << 2;
      gain_loaded = 1'b1;
    end
    c = (c * sbcs_pkg::DECAY_Q32 + (64'd1 << 31)) >> 32;
    c = c > sbcs_pkg::DECAY_SUB ? c - sbcs_pkg::DECAY_SUB : 0;
    if (c < sbcs_pkg::CHASE_FLOOR) c = sbcs_pkg::CHASE_FLOOR;
    chase_speed = c;
    num = gain_smooth * c + (trim_target << 18);
    den = c + 65536;
    g   = (num + den / 2) / den;
    if (g > GAIN_LIMIT) g = GAIN_LIMIT;
    gain_smooth = g;
    p.left  = shape_channel(l, prev_left);
    p.right = shape_channel(r, prev_right);
    return p;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch %s at cycle %0d", what, cycle_count);
  endtask

  // ------------------------------------------------------ result checker
  always @(posedge clk) begin
    stereo_pair_t want;
    if (!rst && out_valid && !out_stall) begin
      if (shaped_pairs_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d", left_out, right_out));
      end else begin
        want = shaped_pairs_q.pop_front();
        if (left_out !== want.left) begin
          report_mismatch($sformatf("left_out: got %0d expected %0d", left_out,
                                    want.left));
        end
        if (right_out !== want.right) begin
          report_mismatch($sformatf("right_out: got %0d expected %0d", right_out,
                                    want.right));
        end
      end
    end
  end

  // ------------------------------------------------------ output receiver
  // draws a stall length per result; a pending hold-off replaces one draw
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 15);
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (n > 0) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ------------------------------------------------------ watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ------------------------------------------------------ stimulus tasks
  // offer one sample pair, hold it until the block takes it
  task automatic send_pair(sample_t l, sample_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (in_stall);
    shaped_pairs_q.push_back(predict_shaped_pair(l, r));
  endtask

  // let every outstanding request finish so registers can be written
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (shaped_pairs_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [sbcs_pkg::CFG_IDX_W-1:0] idx,
                           logic [sbcs_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sbcs_pkg::REG_GAIN_TARGET: trim_target = val;
      sbcs_pkg::REG_RATE_SCALE:  slew_rate   = val[sbcs_pkg::RATE_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t rand_sample(int mode, sample_t prev);
    case (mode)
      0: return sample_t'($urandom);
      1: return sample_t'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return prev + sample_t'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // first request after reset, zero, extremes and mixed signs
  task automatic test_corner_samples();
    send_pair('0, '0);
    send_pair(sample_t'(ONE_S - 1), sample_t'(-ONE_S));
    send_pair(sample_t'(-ONE_S), sample_t'(ONE_S - 1));
    send_pair('0, '0);
    send_pair(sample_t'(1), sample_t'(-1));
    send_pair(sample_t'(4194304), sample_t'(-4194304));
    send_pair(sample_t'(4194304), sample_t'(-4194304));  // no slew, full boost
    drain_requests();
  endtask

  // gain and rate extremes, plus a write to an index past the list
  task automatic test_register_extremes();
    write_reg(sbcs_pkg::REG_GAIN_TARGET, 24'hFFFFFF);
    write_reg(sbcs_pkg::REG_RATE_SCALE, 24'h00FFFF);
    write_reg(REG_UNUSED, 24'h123456);
    send_pair(sample_t'(ONE_S - 1), sample_t'(-ONE_S));
    send_pair(sample_t'(3000000), sample_t'(-3000000));
    send_pair(sample_t'(3000000), sample_t'(-3000000));
    drain_requests();
    write_reg(sbcs_pkg::REG_GAIN_TARGET, '0);
    write_reg(sbcs_pkg::REG_RATE_SCALE, '0);
    send_pair(sample_t'(ONE_S - 1), sample_t'(-ONE_S));
    send_pair(sample_t'(2000000), sample_t'(-2000000));
    drain_requests();
    write_reg(sbcs_pkg::REG_GAIN_TARGET, 24'd4194304);
    write_reg(sbcs_pkg::REG_RATE_SCALE, 24'd4096);
    send_pair(sample_t'(ONE_S - 1), sample_t'(-ONE_S));
    send_pair('0, '0);
    drain_requests();
  endtask

  // random traffic over several settings; half of the samples take small steps
  task automatic test_random_traffic();
    sample_t l, r;
    int mode;
    l = '0;
    r = '0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: write_reg(sbcs_pkg::REG_GAIN_TARGET, sbcs_pkg::CFG_DATA_W'($urandom));
        1: write_reg(sbcs_pkg::REG_GAIN_TARGET,
                     sbcs_pkg::CFG_DATA_W'($urandom_range(2000000, 8000000)));
        2: write_reg(sbcs_pkg::REG_GAIN_TARGET, phase < 4 ? 24'hFFFFFF : 24'd0);
        default: write_reg(sbcs_pkg::REG_GAIN_TARGET, 24'd4194304);
      endcase
      write_reg(sbcs_pkg::REG_RATE_SCALE, phase == 3 ? 24'h00FFFF
                : sbcs_pkg::CFG_DATA_W'($urandom_range(0, 16384)));
      no_idle = (phase == 5);
      for (int i = 0; i < 130; i++) begin
        mode = $urandom_range(0, 3);
        l = rand_sample(mode, l);
        r = rand_sample(mode, r);
        send_pair(l, r);
      end
      no_idle = 1'b0;
      drain_requests();
    end
  endtask

  // long output hold-off while requests keep coming
  task automatic test_output_backpressure();
    hold_off_cycles = 600;
    no_idle = 1'b1;
    for (int i = 0; i < 20; i++) send_pair(sample_t'($urandom), sample_t'($urandom));
    no_idle = 1'b0;
    drain_requests();
  endtask

  // ------------------------------------------------------ main sequence
  initial begin
    trim_target = sbcs_pkg::GAIN_TARGET_RST;
    slew_rate   = sbcs_pkg::RATE_SCALE_RST;
    chase_speed = 0;
    gain_smooth = 0;
    gain_loaded = 1'b0;
    seen_target = 0;
    prev_left   = 0;
    prev_right  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_samples();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();

    repeat (100) @(posedge clk);
    if (error_count == 0 && shaped_pairs_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
